// ===== rtl/tsfm_pkg.sv =====
// Shared types, constants and register map of the touch sample filter and mapper.
package tsfm_pkg;

  localparam int RawW     = 12;
  localparam int CoordW   = 12;
  localparam int PressW   = 13;
  localparam int ProdW    = RawW + CoordW;
  localparam int DivSteps = ProdW;
  localparam int StepCntW = $clog2(DivSteps);

  localparam int QueueDepth = 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  localparam logic [RawW-1:0] FullScale = 12'd4095;

  // register map
  localparam logic [CfgIdxW-1:0] RegXRawLeft          = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXRawRight         = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYRawTop           = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYRawBottom        = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScreenWidth       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScreenHeight      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPressureThreshold = 3'd6;

  typedef struct packed {
    logic [RawW-1:0]   pressure_one;
    logic [RawW-1:0]   pressure_two;
    logic [RawW-1:0]   x_first;
    logic [RawW-1:0]   x_second;
    logic [RawW-1:0]   x_third;
    logic [RawW-1:0]   y_first;
    logic [RawW-1:0]   y_second;
    logic [RawW-1:0]   y_third;
  } sample_t;

  typedef struct packed {
    logic [CoordW-1:0] screen_x;
    logic [CoordW-1:0] screen_y;
    logic [PressW-1:0] pressure;
    logic              touched;
  } result_t;

  typedef struct packed {
    logic [RawW-1:0]   x_raw_left;
    logic [RawW-1:0]   x_raw_right;
    logic [RawW-1:0]   y_raw_top;
    logic [RawW-1:0]   y_raw_bottom;
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
    logic [PressW-1:0] pressure_threshold;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    x_raw_left:         12'd245,
    x_raw_right:        12'd3970,
    y_raw_top:          12'd3870,
    y_raw_bottom:       12'd310,
    screen_width:       12'd480,
    screen_height:      12'd320,
    pressure_threshold: 13'd300
  };

  // one classified sample set, waiting for the mapper
  typedef struct packed {
    logic [RawW-1:0]   held_x;
    logic [RawW-1:0]   held_y;
    logic [PressW-1:0] pressure;
    logic              touched;
  } job_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
  } axis_ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

// ===== rtl/tsfm_front.sv =====
// Front end: pressure, touch decision, closest-pair filter and held raw position.
module tsfm_front import tsfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  sample_t           sample,
  input  logic [PressW-1:0] pressure_threshold,
  input  logic              q_full,
  output logic              q_push,
  output job_t              q_data
);

  function automatic logic [RawW-1:0] pair_avg(input logic [RawW-1:0] a,
                                               input logic [RawW-1:0] b,
                                               input logic [RawW-1:0] c);
    logic [RawW-1:0] d_ab;
    logic [RawW-1:0] d_ac;
    logic [RawW-1:0] d_bc;
    logic [RawW:0]   s;
    d_ab = (a > b) ? a - b : b - a;
    d_ac = (a > c) ? a - c : c - a;
    d_bc = (b > c) ? b - c : c - b;
    // ties go to first/second, then first/third
    if (d_ab <= d_ac && d_ab <= d_bc) begin
      s = {1'b0, a} + {1'b0, b};
    end else if (d_ac <= d_ab && d_ac <= d_bc) begin
      s = {1'b0, a} + {1'b0, c};
    end else begin
      s = {1'b0, b} + {1'b0, c};
    end
    return s[RawW:1];
  endfunction

  logic [RawW-1:0]   held_x;
  logic [RawW-1:0]   held_y;
  logic [RawW-1:0]   held_x_next;
  logic [RawW-1:0]   held_y_next;
  logic [PressW-1:0] press;
  logic              touch;
  logic              accept;

  // Z1 + 4095 - Z2 can never go below zero
  assign press = {1'b0, sample.pressure_one} + {1'b0, FullScale}
               - {1'b0, sample.pressure_two};
  assign touch = press >= pressure_threshold;

  assign sample_ready = !q_full;
  assign accept       = sample_valid && sample_ready;

  always_comb begin
    held_x_next = held_x;
    held_y_next = held_y;
    if (accept && touch) begin
      held_x_next = pair_avg(sample.x_first, sample.x_second, sample.x_third);
      held_y_next = pair_avg(sample.y_first, sample.y_second, sample.y_third);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
    end else begin
      held_x <= held_x_next;
      held_y <= held_y_next;
    end
  end

  assign q_push          = accept;
  assign q_data.held_x   = held_x_next;
  assign q_data.held_y   = held_y_next;
  assign q_data.pressure = touch ? press : '0;
  assign q_data.touched  = touch;

endmodule

// ===== rtl/tsfm_queue.sv =====
// Short register queue between the front end and the mapper.
module tsfm_queue import tsfm_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = count == CntW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tsfm_axis.sv =====
// One axis of the mapper: multiply, restoring divide one bit a cycle, clamp.
module tsfm_axis import tsfm_pkg::*; (
  input  logic              clk,
  input  axis_ctrl_t        ctrl,
  input  logic [RawW-1:0]   raw,
  input  logic [RawW-1:0]   lo,
  input  logic [RawW-1:0]   hi,
  input  logic [CoordW-1:0] size,
  output logic [CoordW-1:0] coord
);

  logic [RawW:0]     diff;
  logic [RawW:0]     span;
  logic [RawW:0]     diff_abs;
  logic [RawW:0]     span_abs;
  logic [RawW:0]     trial;
  logic [RawW:0]     trial_sub;
  logic              fits;

  logic [RawW-1:0]   diff_mag;
  logic [RawW-1:0]   span_mag;
  logic [CoordW-1:0] size_q;
  logic              neg;
  logic              flat;
  logic [ProdW-1:0]  quo;
  logic [RawW-1:0]   rem;

  assign diff     = {1'b0, raw} - {1'b0, lo};
  assign span     = {1'b0, hi} - {1'b0, lo};
  assign diff_abs = diff[RawW] ? -diff : diff;
  assign span_abs = span[RawW] ? -span : span;

  assign trial     = {rem, quo[ProdW-1]};
  assign fits      = trial >= {1'b0, span_mag};
  assign trial_sub = trial - {1'b0, span_mag};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      diff_mag <= diff_abs[RawW-1:0];
      span_mag <= span_abs[RawW-1:0];
      neg      <= diff[RawW] ^ span[RawW];
      flat     <= span == '0;
      size_q   <= size;
    end
    if (ctrl.mul) begin
      quo <= ProdW'(diff_mag) * ProdW'(size_q);
      rem <= '0;
    end
    if (ctrl.step) begin
      rem <= fits ? trial_sub[RawW-1:0] : trial[RawW-1:0];
      quo <= {quo[ProdW-2:0], fits};
    end
  end

  // a negative quotient truncates to zero or below, so it clamps to zero
  always_comb begin
    if (flat || neg) begin
      coord = '0;
    end else if (quo > ProdW'(size_q)) begin
      coord = size_q;
    end else begin
      coord = quo[CoordW-1:0];
    end
  end

endmodule

// ===== rtl/tsfm_back.sv =====
// Back end: sequencer for both axis units and the result register.
module tsfm_back import tsfm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  output logic    q_pop,
  input  job_t    q_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  back_state_t         state;
  back_state_t         state_next;
  logic [StepCntW-1:0] count;
  axis_ctrl_t          ctrl;
  logic                out_load;
  logic [PressW-1:0]   press_q;
  logic                touched_q;
  logic [CoordW-1:0]   coord_x;
  logic [CoordW-1:0]   coord_y;

  tsfm_axis u_axis_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .raw   (q_data.held_x),
    .lo    (cfg.x_raw_left),
    .hi    (cfg.x_raw_right),
    .size  (cfg.screen_width),
    .coord (coord_x)
  );

  tsfm_axis u_axis_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .raw   (q_data.held_y),
    .lo    (cfg.y_raw_top),
    .hi    (cfg.y_raw_bottom),
    .size  (cfg.screen_height),
    .coord (coord_y)
  );

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ctrl       = '0;
    out_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ctrl.load  = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        ctrl.mul   = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        ctrl.step = 1'b1;
        if (count == StepCntW'(DivSteps - 1)) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        // wait for the result register to free up
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_DIV) begin
        count <= (count == StepCntW'(DivSteps - 1)) ? '0 : count + 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      press_q   <= q_data.pressure;
      touched_q <= q_data.touched;
    end
    if (out_load) begin
      result.screen_x <= coord_x;
      result.screen_y <= coord_y;
      result.pressure <= press_q;
      result.touched  <= touched_q;
    end
  end

endmodule

// ===== rtl/touch_sample_filter_map_top.sv =====
// Touch sample filter and screen mapper: top level with configuration registers.
// Each sample set yields one beat carrying pressure, touch flag and the held position
// mapped to screen coordinates. The front end takes a sample set in the cycle it
// arrives, as long as the queue (QUEUE_DEPTH entries) has room; the mapper then
// loads the set, runs the multiply and then the bit-per-cycle divider shared by
// nothing but its own axis, and hands the beat to the result register, waiting
// while the previous beat is not yet taken. The mapper works on one set at a time,
// so later sets wait in the queue until it is done. Write configuration only while
// no sample set is in flight.
module touch_sample_filter_map_top import tsfm_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  sample_t             sample,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t q_wdata;
  job_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegXRawLeft:          cfg.x_raw_left         <= cfg_data[RawW-1:0];
        RegXRawRight:         cfg.x_raw_right        <= cfg_data[RawW-1:0];
        RegYRawTop:           cfg.y_raw_top          <= cfg_data[RawW-1:0];
        RegYRawBottom:        cfg.y_raw_bottom       <= cfg_data[RawW-1:0];
        RegScreenWidth:       cfg.screen_width       <= cfg_data[CoordW-1:0];
        RegScreenHeight:      cfg.screen_height      <= cfg_data[CoordW-1:0];
        RegPressureThreshold: cfg.pressure_threshold <= cfg_data[PressW-1:0];
        default: ;
      endcase
    end
  end

  tsfm_front u_front (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_ready       (sample_ready),
    .sample             (sample),
    .pressure_threshold (cfg.pressure_threshold),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_wdata)
  );

  tsfm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  tsfm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_press_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.touched ? (result.pressure >= cfg.pressure_threshold)
                                     : (result.pressure == '0)))
    else $error("pressure and touch flag disagree");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.screen_x <= cfg.screen_width &&
                      result.screen_y <= cfg.screen_height))
    else $error("coordinate beyond screen size");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat straight after reset");
`endif

endmodule
